/* rtl/core/flow_hover_and_land_controller_macros.svh */
// Assertion macros for the hover and landing controller.
`ifndef FLOW_HOVER_AND_LAND_CONTROLLER_MACROS_SVH
`define FLOW_HOVER_AND_LAND_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FHLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FHLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/fhlc_pkg.sv */
// Types and constants shared by the hover and landing controller.
package fhlc_pkg;

	// mode codes on the tick channel
	localparam logic [1:0] MODE_HOVER = 2'd0;
	localparam logic [1:0] MODE_LAND  = 2'd1;

	// output_kind codes
	localparam logic [1:0] KIND_HOVER = 2'd0;
	localparam logic [1:0] KIND_LAND  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_USE_FLOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_P      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_I      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_P     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_I     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_TARGET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAND_GAIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VSPEED_LIM  = 3'd7;
	localparam int unsigned CFG_DATA_W = 32;

	typedef struct packed {
		logic               use_flow;
		logic [15:0]        roll_p;
		logic [15:0]        roll_i;
		logic [15:0]        pitch_p;
		logic [15:0]        pitch_i;
		logic signed [23:0] div_target;
		logic [31:0]        land_gain;
		logic [30:0]        vspeed_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		use_flow:     1'b0,
		roll_p:       16'd500,
		roll_i:       16'd10,
		pitch_p:      16'd500,
		pitch_i:      16'd10,
		div_target:   24'sd0,
		land_gain:    32'd0,
		vspeed_limit: 31'd526315
	};

	// products and landing increment registered at the input stage
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [32:0] xp;
		logic signed [32:0] xi;
		logic signed [32:0] yp;
		logic signed [32:0] yi;
		logic signed [15:0] heading;
		logic signed [25:0] land_inc;
	} s1_t;

endpackage

/* rtl/core/fhlc_if.sv */
// Tick and result channel interfaces of the hover and landing controller.
interface fhlc_tick_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] flow_vel_x;
	logic signed [15:0] flow_vel_y;
	logic signed [15:0] body_vel_x;
	logic signed [15:0] body_vel_y;
	logic signed [23:0] divergence;
	logic signed [15:0] current_heading;

	modport source (
		output valid, mode, flow_vel_x, flow_vel_y, body_vel_x, body_vel_y,
			divergence, current_heading,
		input ready
	);
	modport sink (
		input valid, mode, flow_vel_x, flow_vel_y, body_vel_x, body_vel_y,
			divergence, current_heading,
		output ready
	);
endinterface

interface fhlc_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         output_kind;
	logic signed [11:0] roll_cmd;
	logic signed [11:0] pitch_cmd;
	logic signed [15:0] heading_cmd;
	logic               roll_limited;
	logic               pitch_limited;
	logic signed [31:0] vspeed_setpoint;

	modport source (
		output valid, output_kind, roll_cmd, pitch_cmd, heading_cmd, roll_limited,
			pitch_limited, vspeed_setpoint,
		input ready
	);
	modport sink (
		input valid, output_kind, roll_cmd, pitch_cmd, heading_cmd, roll_limited,
			pitch_limited, vspeed_setpoint,
		output ready
	);
endinterface

/* rtl/core/flow_hover_and_land_controller.sv */
// A tick is registered in the input stage, then in the held state that forms the result word.
// One tick per cycle while the result side keeps taking words; the integrator/setpoint update is combinational.
// Gain products are registered at the input stage; state updates when that stage advances to the output.
// A result word waiting on the output does not block the input register from filling.
// Reset (arst_n low, async) loads the register defaults and clears all held state.
`include "flow_hover_and_land_controller_macros.svh"

module flow_hover_and_land_controller #(
	parameter int CMD_LIMIT = 1500
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [fhlc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fhlc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	fhlc_tick_if.sink                              tick,
	fhlc_result_if.source                          result
);

	localparam logic signed [32:0] PLIM = 33'(CMD_LIMIT);
	localparam logic signed [33:0] RLIM = 34'(CMD_LIMIT);
	localparam logic signed [39:0] INT_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] INT_MIN = {1'b1, {39{1'b0}}};
	localparam logic signed [31:0] VS_MAX  = {1'b0, {31{1'b1}}};
	localparam logic signed [31:0] VS_MIN  = {1'b1, {31{1'b0}}};

	fhlc_pkg::cfg_t     cfg_q;
	fhlc_pkg::s1_t      s1_s1;
	logic               s1_valid_q;
	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic               advance;
	logic               load;

	logic signed [39:0] x_integral_q;
	logic signed [39:0] y_integral_q;
	logic               roll_clamped_q;
	logic               pitch_clamped_q;
	logic               heading_pending_q;
	logic signed [15:0] heading_hold_q;
	logic signed [11:0] roll_hold_q;
	logic signed [11:0] pitch_hold_q;
	logic signed [31:0] vspeed_acc_q;

	// hover datapath
	logic signed [40:0] x_sum;
	logic signed [40:0] y_sum;
	logic signed [39:0] x_sat;
	logic signed [39:0] y_sat;
	logic signed [39:0] x_new;
	logic signed [39:0] y_new;
	logic signed [40:0] p_q8;
	logic signed [40:0] p_adj;
	logic signed [32:0] p_int;
	logic signed [40:0] r_pos;
	logic signed [41:0] r_q8;
	logic signed [41:0] r_adj;
	logic signed [33:0] r_int;
	logic signed [11:0] pitch_new;
	logic signed [11:0] roll_new;
	logic               pitch_lim;
	logic               roll_lim;

	// landing datapath
	logic signed [32:0] vs_sum;
	logic signed [31:0] vs_sat;
	logic signed [32:0] vs_lim_pos;
	logic signed [32:0] vs_lim_neg;
	logic signed [31:0] vs_new;

	// handshake: the input register moves on whenever the output slot frees up
	assign advance    = !out_valid_q || result.ready;
	assign tick.ready = !s1_valid_q || advance;
	assign load       = tick.valid && tick.ready;

	fhlc_front u_front (
		.clk             (clk),
		.load            (load),
		.cfg             (cfg_q),
		.mode            (tick.mode),
		.flow_vel_x      (tick.flow_vel_x),
		.flow_vel_y      (tick.flow_vel_y),
		.body_vel_x      (tick.body_vel_x),
		.body_vel_y      (tick.body_vel_y),
		.divergence      (tick.divergence),
		.current_heading (tick.current_heading),
		.s1              (s1_s1)
	);

	// integrators: conditional integration with 40-bit saturation
	assign x_sum = {x_integral_q[39], x_integral_q} + {{8{s1_s1.xi[32]}}, s1_s1.xi};
	assign y_sum = {y_integral_q[39], y_integral_q} + {{8{s1_s1.yi[32]}}, s1_s1.yi};
	assign x_sat = (x_sum[40] != x_sum[39]) ? (x_sum[40] ? INT_MIN : INT_MAX) : x_sum[39:0];
	assign y_sat = (y_sum[40] != y_sum[39]) ? (y_sum[40] ? INT_MIN : INT_MAX) : y_sum[39:0];
	assign x_new = pitch_clamped_q ? x_integral_q : x_sat;
	assign y_new = roll_clamped_q ? y_integral_q : y_sat;

	// Q.8 to integer, truncating toward zero
	assign p_q8  = {x_new[39], x_new} + {{8{s1_s1.xp[32]}}, s1_s1.xp};
	assign p_adj = p_q8 + (p_q8[40] ? 41'sd255 : 41'sd0);
	assign p_int = p_adj[40:8];

	assign r_pos = {y_new[39], y_new} + {{8{s1_s1.yp[32]}}, s1_s1.yp};
	assign r_q8  = -{r_pos[40], r_pos};
	assign r_adj = r_q8 + (r_q8[41] ? 42'sd255 : 42'sd0);
	assign r_int = r_adj[41:8];

	always_comb begin
		pitch_lim = 1'b1;
		if (p_int > PLIM) begin
			pitch_new = 12'(PLIM);
		end else if (p_int < -PLIM) begin
			pitch_new = 12'(-PLIM);
		end else begin
			pitch_new = 12'(p_int);
			pitch_lim = 1'b0;
		end
		roll_lim = 1'b1;
		if (r_int > RLIM) begin
			roll_new = 12'(RLIM);
		end else if (r_int < -RLIM) begin
			roll_new = 12'(-RLIM);
		end else begin
			roll_new = 12'(r_int);
			roll_lim = 1'b0;
		end
	end

	// vertical speed: 32-bit saturation, then the symmetric limit
	assign vs_sum     = {vspeed_acc_q[31], vspeed_acc_q} + {{7{s1_s1.land_inc[25]}}, s1_s1.land_inc};
	assign vs_sat     = (vs_sum[32] != vs_sum[31]) ? (vs_sum[32] ? VS_MIN : VS_MAX) : vs_sum[31:0];
	assign vs_lim_pos = $signed({2'b00, cfg_q.vspeed_limit});
	assign vs_lim_neg = -vs_lim_pos;

	always_comb begin
		if ($signed({vs_sat[31], vs_sat}) > vs_lim_pos) begin
			vs_new = vs_lim_pos[31:0];
		end else if ($signed({vs_sat[31], vs_sat}) < vs_lim_neg) begin
			vs_new = vs_lim_neg[31:0];
		end else begin
			vs_new = vs_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fhlc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fhlc_pkg::REG_USE_FLOW:   cfg_q.use_flow     <= cfg_wdata[0];
				fhlc_pkg::REG_ROLL_P:     cfg_q.roll_p       <= cfg_wdata[15:0];
				fhlc_pkg::REG_ROLL_I:     cfg_q.roll_i       <= cfg_wdata[15:0];
				fhlc_pkg::REG_PITCH_P:    cfg_q.pitch_p      <= cfg_wdata[15:0];
				fhlc_pkg::REG_PITCH_I:    cfg_q.pitch_i      <= cfg_wdata[15:0];
				fhlc_pkg::REG_DIV_TARGET: cfg_q.div_target   <= $signed(cfg_wdata[23:0]);
				fhlc_pkg::REG_LAND_GAIN:  cfg_q.land_gain    <= cfg_wdata[31:0];
				fhlc_pkg::REG_VSPEED_LIM: cfg_q.vspeed_limit <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= load || (s1_valid_q && !advance);
			out_valid_q <= (s1_valid_q && advance) || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_kind_q        <= fhlc_pkg::KIND_CLEAR;
			x_integral_q      <= '0;
			y_integral_q      <= '0;
			roll_clamped_q    <= 1'b0;
			pitch_clamped_q   <= 1'b0;
			heading_pending_q <= 1'b1;
			heading_hold_q    <= '0;
			roll_hold_q       <= '0;
			pitch_hold_q      <= '0;
			vspeed_acc_q      <= '0;
		end else if (s1_valid_q && advance) begin
			case (s1_s1.mode)
				fhlc_pkg::MODE_HOVER: begin
					out_kind_q      <= fhlc_pkg::KIND_HOVER;
					x_integral_q    <= x_new;
					y_integral_q    <= y_new;
					roll_hold_q     <= roll_new;
					pitch_hold_q    <= pitch_new;
					roll_clamped_q  <= roll_lim;
					pitch_clamped_q <= pitch_lim;
					if (heading_pending_q) begin
						heading_hold_q    <= s1_s1.heading;
						heading_pending_q <= 1'b0;
					end
				end
				fhlc_pkg::MODE_LAND: begin
					out_kind_q   <= fhlc_pkg::KIND_LAND;
					vspeed_acc_q <= vs_new;
				end
				default: begin
					out_kind_q   <= fhlc_pkg::KIND_CLEAR;
					x_integral_q <= '0;
					y_integral_q <= '0;
				end
			endcase
		end
	end

	// the held state is the result word; it cannot move while the word waits
	assign result.valid           = out_valid_q;
	assign result.output_kind     = out_kind_q;
	assign result.roll_cmd        = roll_hold_q;
	assign result.pitch_cmd       = pitch_hold_q;
	assign result.heading_cmd     = heading_hold_q;
	assign result.roll_limited    = roll_clamped_q && (out_kind_q == fhlc_pkg::KIND_HOVER);
	assign result.pitch_limited   = pitch_clamped_q && (out_kind_q == fhlc_pkg::KIND_HOVER);
	assign result.vspeed_setpoint = vspeed_acc_q;

	`FHLC_ASSERT_NEXT(a_state_frozen_on_stall, clk, arst_n, out_valid_q && !result.ready, $stable(x_integral_q) && $stable(y_integral_q) && $stable(vspeed_acc_q), "state changed while result word stalled")
	`FHLC_ASSERT_NOW(a_roll_in_range, clk, arst_n, out_valid_q, (roll_hold_q <= 12'(RLIM)) && (roll_hold_q >= 12'(-RLIM)), "roll command outside limit")
	`FHLC_ASSERT_NOW(a_vspeed_in_range, clk, arst_n, out_valid_q && (out_kind_q == fhlc_pkg::KIND_LAND), ($signed({vspeed_acc_q[31], vspeed_acc_q}) <= vs_lim_pos) && ($signed({vspeed_acc_q[31], vspeed_acc_q}) >= vs_lim_neg), "vertical setpoint outside limit")
	`FHLC_ASSERT_NOW(a_heading_latch_on_hover, clk, arst_n, $fell(heading_pending_q), out_valid_q && (out_kind_q == fhlc_pkg::KIND_HOVER), "heading latched outside a hover update")

endmodule

/* rtl/core/fhlc_front.sv */
// Input stage: velocity select, gain products and landing increment, registered.
module fhlc_front (
	input  logic                clk,
	input  logic                load,
	input  fhlc_pkg::cfg_t      cfg,
	input  logic [1:0]          mode,
	input  logic signed [15:0]  flow_vel_x,
	input  logic signed [15:0]  flow_vel_y,
	input  logic signed [15:0]  body_vel_x,
	input  logic signed [15:0]  body_vel_y,
	input  logic signed [23:0]  divergence,
	input  logic signed [15:0]  current_heading,
	output fhlc_pkg::s1_t       s1
);

	logic signed [15:0] vx;
	logic signed [15:0] vy;
	logic signed [16:0] pitch_p_s;
	logic signed [16:0] pitch_i_s;
	logic signed [16:0] roll_p_s;
	logic signed [16:0] roll_i_s;
	logic signed [32:0] xp;
	logic signed [32:0] xi;
	logic signed [32:0] yp;
	logic signed [32:0] yi;
	logic signed [24:0] err;
	logic [24:0]        mag;
	logic [56:0]        prod;
	logic [24:0]        inc_mag;
	logic signed [25:0] inc_pos;
	logic signed [25:0] land_inc;
	fhlc_pkg::s1_t      s1_s1;

	assign vx = cfg.use_flow ? flow_vel_x : body_vel_x;
	assign vy = cfg.use_flow ? flow_vel_y : body_vel_y;

	assign pitch_p_s = $signed({1'b0, cfg.pitch_p});
	assign pitch_i_s = $signed({1'b0, cfg.pitch_i});
	assign roll_p_s  = $signed({1'b0, cfg.roll_p});
	assign roll_i_s  = $signed({1'b0, cfg.roll_i});

	assign xp = pitch_p_s * vx;
	assign xi = pitch_i_s * vx;
	assign yp = roll_p_s * vy;
	assign yi = roll_i_s * vy;

	// landing: sign-magnitude product, Q.32 truncated toward zero
	assign err     = {cfg.div_target[23], cfg.div_target} - {divergence[23], divergence};
	assign mag     = err[24] ? 25'(-err) : 25'(err);
	assign prod    = 57'(cfg.land_gain) * 57'(mag);
	assign inc_mag = prod[56:32];
	assign inc_pos = $signed({1'b0, inc_mag});
	assign land_inc = err[24] ? -inc_pos : inc_pos;

	always_ff @(posedge clk) begin
		if (load) begin
			s1_s1.mode     <= mode;
			s1_s1.xp       <= xp;
			s1_s1.xi       <= xi;
			s1_s1.yp       <= yp;
			s1_s1.yi       <= yi;
			s1_s1.heading  <= current_heading;
			s1_s1.land_inc <= land_inc;
		end
	end

	assign s1 = s1_s1;

endmodule

/* verif/tb_flow_hover_and_land_controller.sv */
// Testbench for the hover and landing controller: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module tb_flow_hover_and_land_controller;

	localparam logic [1:0]  MODE_OTHER   = 2'd2;
	localparam logic [1:0]  MODE_SPARE   = 2'd3;
	localparam longint      CMD_LIMIT    = 1500;
	localparam longint      ACC_MAX      = 64'sd549755813887;
	localparam longint      ACC_MIN      = -ACC_MAX - 1;
	localparam longint      VS_MAX       = 64'sd2147483647;
	localparam longint      VS_MIN       = -64'sd2147483648;
	localparam int unsigned DRAIN_LIMIT  = 5000;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] flow_vel_x;
		logic signed [15:0] flow_vel_y;
		logic signed [15:0] body_vel_x;
		logic signed [15:0] body_vel_y;
		logic signed [23:0] divergence;
		logic signed [15:0] current_heading;
	} tick_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [11:0] roll;
		logic signed [11:0] pitch;
		logic signed [15:0] heading;
		logic               roll_lim;
		logic               pitch_lim;
		logic signed [31:0] vspeed;
	} ctrl_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [fhlc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fhlc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	fhlc_tick_if   tick_ch ();
	fhlc_result_if res_ch ();

	flow_hover_and_land_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.result    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	fhlc_pkg::cfg_t     gains;
	longint             x_acc, y_acc;
	bit                 roll_frozen, pitch_frozen, heading_open;
	logic signed [15:0] heading_latch;
	logic signed [11:0] roll_held, pitch_held;
	logic signed [31:0] vspeed_held;

	ctrl_word_t  pending_cmds[$];
	int unsigned mismatches = 0;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	int unsigned rx_hold_req = 0;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("%0t ERROR %s", $time, msg);
		mismatches++;
	endtask

	function automatic void reset_controller();
		gains         = fhlc_pkg::CFG_RESET;
		x_acc         = 0;
		y_acc         = 0;
		roll_frozen   = 1'b0;
		pitch_frozen  = 1'b0;
		heading_open  = 1'b1;
		heading_latch = '0;
		roll_held     = '0;
		pitch_held    = '0;
		vspeed_held   = '0;
	endfunction

	function automatic longint sat40(input longint v);
		if (v > ACC_MAX) return ACC_MAX;
		if (v < ACC_MIN) return ACC_MIN;
		return v;
	endfunction

	// Q.8 to integer toward zero, then clamp to the command range
	function automatic logic signed [11:0] clamp_cmd(input longint q8, output bit hit);
		longint c;
		c = q8 / 256;
		hit = 1'b0;
		if (c > CMD_LIMIT) begin
			c = CMD_LIMIT;
			hit = 1'b1;
		end else if (c < -CMD_LIMIT) begin
			c = -CMD_LIMIT;
			hit = 1'b1;
		end
		return c[11:0];
	endfunction

	// advances the controller by one tick and queues the word it produces
	function automatic void advance_controller(input tick_t t);
		ctrl_word_t        w;
		longint            vx, vy, kp, ki, tgt, dv, err, inc, s, lim;
		longint unsigned   mag, gain_u, incm;
		bit                rlim, plim;
		rlim = 1'b0;
		plim = 1'b0;
		case (t.mode)
			fhlc_pkg::MODE_HOVER: begin
				vx = gains.use_flow ? longint'(t.flow_vel_x) : longint'(t.body_vel_x);
				vy = gains.use_flow ? longint'(t.flow_vel_y) : longint'(t.body_vel_y);
				// pitch clamp freezes x, roll clamp freezes y
				if (!pitch_frozen) begin
					ki = longint'(gains.pitch_i);
					x_acc = sat40(x_acc + ki * vx);
				end
				if (!roll_frozen) begin
					ki = longint'(gains.roll_i);
					y_acc = sat40(y_acc + ki * vy);
				end
				if (heading_open) begin
					heading_latch = t.current_heading;
					heading_open = 1'b0;
				end
				kp = longint'(gains.roll_p);
				roll_held = clamp_cmd(-(kp * vy + y_acc), rlim);
				kp = longint'(gains.pitch_p);
				pitch_held = clamp_cmd(kp * vx + x_acc, plim);
				roll_frozen = rlim;
				pitch_frozen = plim;
				w.kind = fhlc_pkg::KIND_HOVER;
			end
			fhlc_pkg::MODE_LAND: begin
				tgt = longint'(gains.div_target);
				dv = longint'(t.divergence);
				err = tgt - dv;
				mag = (err < 0) ? -err : err;
				gain_u = longint'(gains.land_gain);
				incm = (gain_u * mag) >> 32;
				inc = (err < 0) ? -longint'(incm) : longint'(incm);
				s = longint'(vspeed_held) + inc;
				if (s > VS_MAX) s = VS_MAX;
				if (s < VS_MIN) s = VS_MIN;
				lim = longint'(gains.vspeed_limit);
				if (s > lim) s = lim;
				if (s < -lim) s = -lim;
				vspeed_held = s[31:0];
				w.kind = fhlc_pkg::KIND_LAND;
			end
			default: begin
				x_acc = 0;
				y_acc = 0;
				w.kind = fhlc_pkg::KIND_CLEAR;
			end
		endcase
		w.roll      = roll_held;
		w.pitch     = pitch_held;
		w.heading   = heading_latch;
		w.roll_lim  = rlim;
		w.pitch_lim = plim;
		w.vspeed    = vspeed_held;
		pending_cmds.push_back(w);
	endfunction

	// mostly zero, some short, a few long
	function automatic int unsigned idle_span(input bit enabled);
		int unsigned r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] vel_sample(input bit gentle);
		if (gentle) return 16'($urandom_range(0, 1535)) - 16'd768;
		return 16'($urandom);
	endfunction

	function automatic tick_t random_tick(input logic [1:0] m, input bit gentle);
		tick_t t;
		t.mode            = m;
		t.flow_vel_x      = vel_sample(gentle);
		t.flow_vel_y      = vel_sample(gentle);
		t.body_vel_x      = vel_sample(gentle);
		t.body_vel_y      = vel_sample(gentle);
		if (gentle)
			t.divergence = gains.div_target + 24'($urandom_range(0, 131072)) - 24'd65536;
		else
			t.divergence = 24'($urandom);
		t.current_heading = 16'($urandom);
		return t;
	endfunction

	function automatic tick_t make_tick(input logic [1:0] m, input int fx, input int fy,
			input int bx, input int by, input int dv, input int hd);
		tick_t t;
		t.mode            = m;
		t.flow_vel_x      = 16'(fx);
		t.flow_vel_y      = 16'(fy);
		t.body_vel_x      = 16'(bx);
		t.body_vel_y      = 16'(by);
		t.divergence      = 24'(dv);
		t.current_heading = 16'(hd);
		return t;
	endfunction

	function automatic logic [15:0] gain16();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5) return 16'h0000;
		if (r < 10) return 16'hFFFF;
		if (r < 20) return 16'($urandom);
		return 16'($urandom_range(0, 1200));
	endfunction

	function automatic fhlc_pkg::cfg_t gain_set(input bit uf, input int unsigned rp,
			input int unsigned ri, input int unsigned pp, input int unsigned pi, input int dt,
			input int unsigned lg, input int unsigned vl);
		fhlc_pkg::cfg_t c;
		c.use_flow     = uf;
		c.roll_p       = 16'(rp);
		c.roll_i       = 16'(ri);
		c.pitch_p      = 16'(pp);
		c.pitch_i      = 16'(pi);
		c.div_target   = 24'(dt);
		c.land_gain    = lg;
		c.vspeed_limit = 31'(vl);
		return c;
	endfunction

	function automatic fhlc_pkg::cfg_t random_gains();
		fhlc_pkg::cfg_t c;
		c.use_flow = 1'($urandom_range(0, 1));
		c.roll_p   = gain16();
		c.roll_i   = gain16();
		c.pitch_p  = gain16();
		c.pitch_i  = gain16();
		if ($urandom_range(0, 3) == 0)
			c.div_target = 24'($urandom);
		else
			c.div_target = 24'($urandom_range(0, 131072)) - 24'd65536;
		case ($urandom_range(0, 5))
			0: c.land_gain = 32'h0000_0000;
			1: c.land_gain = 32'hFFFF_FFFF;
			2: c.land_gain = $urandom;
			default: c.land_gain = $urandom_range(0, 32'h1000_0000);
		endcase
		case ($urandom_range(0, 4))
			0: c.vspeed_limit = 31'd0;
			1: c.vspeed_limit = 31'h7FFF_FFFF;
			2: c.vspeed_limit = 31'd526315;
			default: c.vspeed_limit = 31'($urandom_range(0, 2000000));
		endcase
		return c;
	endfunction

	task automatic put_reg(input logic [fhlc_pkg::CFG_IDX_W-1:0] idx,
			input logic [fhlc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// block must be idle when this is called
	task automatic write_regs(input fhlc_pkg::cfg_t c);
		put_reg(fhlc_pkg::REG_USE_FLOW,   {31'd0, c.use_flow});
		put_reg(fhlc_pkg::REG_ROLL_P,     {16'd0, c.roll_p});
		put_reg(fhlc_pkg::REG_ROLL_I,     {16'd0, c.roll_i});
		put_reg(fhlc_pkg::REG_PITCH_P,    {16'd0, c.pitch_p});
		put_reg(fhlc_pkg::REG_PITCH_I,    {16'd0, c.pitch_i});
		put_reg(fhlc_pkg::REG_DIV_TARGET, {{8{c.div_target[23]}}, c.div_target});
		put_reg(fhlc_pkg::REG_LAND_GAIN,  c.land_gain);
		put_reg(fhlc_pkg::REG_VSPEED_LIM, {1'b0, c.vspeed_limit});
		cfg_we <= 1'b0;
		gains = c;
	endtask

	task automatic send_tick(input tick_t t);
		int unsigned gap;
		gap = idle_span(tx_gaps);
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid           <= 1'b1;
		tick_ch.mode            <= t.mode;
		tick_ch.flow_vel_x      <= t.flow_vel_x;
		tick_ch.flow_vel_y      <= t.flow_vel_y;
		tick_ch.body_vel_x      <= t.body_vel_x;
		tick_ch.body_vel_y      <= t.body_vel_y;
		tick_ch.divergence      <= t.divergence;
		tick_ch.current_heading <= t.current_heading;
		@(posedge clk);
		while (tick_ch.ready !== 1'b1) @(posedge clk);
		advance_controller(t);
	endtask

	// stop offering ticks and let every outstanding word come back
	task automatic wait_all_results();
		int unsigned waited;
		waited = 0;
		tick_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_cmds.size() != 0) begin
			report_mismatch($sformatf("%0d result words never arrived", pending_cmds.size()));
			pending_cmds.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		// body velocity selected, default gains, heading latches on first hover tick
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 5000, -5000, 100, -50, 0, -32768));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, 0, 0, 0, 32767));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, -32768, 32767, 32767, -32768, 0, 1234));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 1, 1, 32767, -32768, 0, -1));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 32767, -32768, 0, 0, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, -32768, 32767, 0, 0));
		send_tick(make_tick(MODE_OTHER, 32767, 32767, 32767, 32767, 8388607, 32767));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, 200, 200, 0, 0));
		send_tick(make_tick(MODE_SPARE, -32768, -32768, -32768, -32768, -8388608, -32768));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 8388607, 0));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, -8388608, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, -32768, -32768, 0, 0));
	endtask

	task automatic test_register_extremes();
		// everything at its top value, flow velocity selected
		wait_all_results();
		write_regs(gain_set(1'b1, 65535, 65535, 65535, 65535, 8388607, 32'hFFFF_FFFF,
			32'h7FFF_FFFF));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, -32768, 32767, 5, 5, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 32767, -32768, 5, 5, 0, 0));
		send_tick(make_tick(MODE_OTHER, 0, 0, 0, 0, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 8388607, 0));
		// largest positive increment, long enough to hit the 32-bit ceiling
		for (int k = 0; k < 130; k++)
			send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, -8388608, 0));

		// zero gains and zero limit: setpoint collapses to zero
		wait_all_results();
		write_regs(gain_set(1'b0, 0, 0, 0, 0, -8388608, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 8388607, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 32767, 32767, -32768, 32767, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, 0, 0, 0, 0));

		// largest negative increment down to the 32-bit floor
		wait_all_results();
		write_regs(gain_set(1'b0, 1, 65535, 1, 65535, -8388608, 32'hFFFF_FFFF,
			32'h7FFF_FFFF));
		for (int k = 0; k < 130; k++)
			send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 8388607, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, 32767, -32768, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, 32767, -32768, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 0, 0, -32768, 32767, 0, 0));

		// small landing gain (0x0001_0000 in Q.32), tight limit
		wait_all_results();
		write_regs(gain_set(1'b1, 300, 40, 700, 3, 65536, 32'h0001_0000, 1000));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 0, 0));
		send_tick(make_tick(fhlc_pkg::MODE_LAND, 0, 0, 0, 0, 131072, 0));
		send_tick(make_tick(fhlc_pkg::MODE_HOVER, 300, -300, 0, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		wait_all_results();
		write_regs(fhlc_pkg::CFG_RESET);
		// result side holds off while ticks keep coming, so the input stalls
		rx_hold_req = 300;
		for (int k = 0; k < 40; k++)
			send_tick(random_tick((k % 3 == 0) ? fhlc_pkg::MODE_LAND : fhlc_pkg::MODE_HOVER,
				1'b1));
		wait_all_results();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_random_flight(input int unsigned n_items);
		tick_t       t;
		int unsigned sent, next_cfg, pick, run;
		logic [1:0]  noise_mode;
		sent = 0;
		next_cfg = 0;
		while (sent < n_items) begin
			if (sent >= next_cfg) begin
				wait_all_results();
				write_regs(random_gains());
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
				next_cfg += 120;
			end
			pick = $urandom_range(0, 99);
			run = $urandom_range(1, 30);
			for (int k = 0; k < run; k++) begin
				noise_mode = 2'($urandom_range(0, 3));
				if (pick < 45)
					t = random_tick(fhlc_pkg::MODE_HOVER, $urandom_range(0, 4) != 0);
				else if (pick < 80)
					t = random_tick(fhlc_pkg::MODE_LAND, $urandom_range(0, 4) != 0);
				else if (pick < 88)
					t = random_tick(noise_mode[0] ? MODE_SPARE : MODE_OTHER, 1'b0);
				else
					t = random_tick(noise_mode, $urandom_range(0, 1) != 0);
				send_tick(t);
				sent++;
			end
		end
	endtask

	initial begin : result_monitor
		ctrl_word_t  got, want;
		int unsigned stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.kind      = res_ch.output_kind;
				got.roll      = res_ch.roll_cmd;
				got.pitch     = res_ch.pitch_cmd;
				got.heading   = res_ch.heading_cmd;
				got.roll_lim  = res_ch.roll_limited;
				got.pitch_lim = res_ch.pitch_limited;
				got.vspeed    = res_ch.vspeed_setpoint;
				if (pending_cmds.size() == 0) begin
					report_mismatch("result word with no tick outstanding");
				end else begin
					want = pending_cmds.pop_front();
					if (got.kind !== want.kind)
						report_mismatch($sformatf("output_kind %0d, expected %0d",
							got.kind, want.kind));
					if (got.roll !== want.roll)
						report_mismatch($sformatf("roll_cmd %0d, expected %0d",
							got.roll, want.roll));
					if (got.pitch !== want.pitch)
						report_mismatch($sformatf("pitch_cmd %0d, expected %0d",
							got.pitch, want.pitch));
					if (got.heading !== want.heading)
						report_mismatch($sformatf("heading_cmd %0d, expected %0d",
							got.heading, want.heading));
					if (got.roll_lim !== want.roll_lim)
						report_mismatch($sformatf("roll_limited %b, expected %b",
							got.roll_lim, want.roll_lim));
					if (got.pitch_lim !== want.pitch_lim)
						report_mismatch($sformatf("pitch_limited %b, expected %b",
							got.pitch_lim, want.pitch_lim));
					if (got.vspeed !== want.vspeed)
						report_mismatch($sformatf("vspeed_setpoint %0d, expected %0d",
							got.vspeed, want.vspeed));
				end
			end
			if (stall > 0) begin
				stall--;
			end else if (rx_hold_req > 0) begin
				stall = rx_hold_req;
				rx_hold_req = 0;
			end else begin
				stall = idle_span(rx_gaps);
			end
			res_ch.ready <= (stall == 0);
		end
	end

	initial begin : run_limit
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= fhlc_pkg::REG_USE_FLOW;
		cfg_wdata               <= '0;
		tick_ch.valid           <= 1'b0;
		tick_ch.mode            <= fhlc_pkg::MODE_HOVER;
		tick_ch.flow_vel_x      <= '0;
		tick_ch.flow_vel_y      <= '0;
		tick_ch.body_vel_x      <= '0;
		tick_ch.body_vel_y      <= '0;
		tick_ch.divergence      <= '0;
		tick_ch.current_heading <= '0;
		reset_controller();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_flight(1225);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
